FILE: sv/cltk_pkg.sv
`default_nettype none

package cltk_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int FRONT_DEPTH       = 2;
    localparam int RESULT_DEPTH      = 4;

    typedef enum logic [2:0] {
        KIND_NAME      = 3'd0,
        KIND_NUMBER    = 3'd1,
        KIND_OPERATOR  = 3'd2,
        KIND_BRACKET   = 3'd3,
        KIND_COMMA     = 3'd4,
        KIND_SEMICOLON = 3'd5,
        KIND_ERROR     = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE                = 3'd0,
        ERR_LETTER_AFTER_NUMBER = 3'd1,
        ERR_MISPLACED_DOT       = 3'd2,
        ERR_UNKNOWN_BYTE        = 3'd3,
        ERR_OPEN_COMMENT        = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        MODE_IDLE          = 3'd0,
        MODE_NAME          = 3'd1,
        MODE_NUMBER        = 3'd2,
        MODE_OPERATOR      = 3'd3,
        MODE_LINE_COMMENT  = 3'd4,
        MODE_BLOCK_COMMENT = 3'd5,
        MODE_HALT          = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        CL_BLANK,
        CL_NEWLINE,
        CL_COMMA,
        CL_SEMI,
        CL_BRACKET,
        CL_ALPHA,
        CL_SUFFIX,
        CL_DIGIT,
        CL_DOT,
        CL_SLASH,
        CL_STAR,
        CL_OPER,
        CL_UNKNOWN
    } cls_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        cls_t       cls;
        logic [7:0] char_code;
        logic       end_of_text;
    } class_item_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [7:0]  single_char;
        err_t        error_code;
        logic        last_of_run;
    } result_t;

    // write request from the lexer into the result queue
    typedef struct packed {
        logic en0;
        logic en1;
    } wr_req_t;

endpackage

`default_nettype wire

FILE: sv/cltk_front.sv
`default_nettype none

module cltk_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  cltk_pkg::in_item_t    item,
    output logic                  out_valid,
    input  logic                  out_take,
    output cltk_pkg::class_item_t out_item
);
    import cltk_pkg::*;

    localparam int PTR_BITS = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FRONT_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(FRONT_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(FRONT_DEPTH);

    localparam logic [7:0] CH_D          = 8'h64;
    localparam logic [7:0] CH_F          = 8'h66;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t k;
        unique case (c) inside
            CH_D, CH_F:                                      k = CL_SUFFIX;
            [8'h41:8'h5A], [8'h61:8'h63], 8'h65, [8'h67:8'h7A],
            CH_UNDERSCORE:                                   k = CL_ALPHA;
            [8'h30:8'h39]:                                   k = CL_DIGIT;
            8'h20, 8'h09:                                    k = CL_BLANK;
            8'h0A:                                           k = CL_NEWLINE;
            8'h2C:                                           k = CL_COMMA;
            8'h3B:                                           k = CL_SEMI;
            8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D:        k = CL_BRACKET;
            8'h2E:                                           k = CL_DOT;
            8'h2F:                                           k = CL_SLASH;
            8'h2A:                                           k = CL_STAR;
            8'h2B, 8'h2D, 8'h21, 8'h5E, 8'h3D, 8'h7E, 8'h3C, 8'h3E, 8'h7C,
            8'h25:                                           k = CL_OPER;
            default:                                         k = CL_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    class_item_t           slot_reg [FRONT_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;
    class_item_t           new_item;

    assign full      = (count_reg == CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = out_take && out_valid;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.cls         = classify(item.char_code);
        new_item.char_code   = item.char_code;
        new_item.end_of_text = item.end_of_text;
    end

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = CNT_BITS'(count_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cltk_lexer.sv
`default_nettype none

module cltk_lexer #(
    parameter int POSITION_BITS = cltk_pkg::POSITION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_take,
    input  cltk_pkg::class_item_t in_item,
    input  logic                  room,
    output cltk_pkg::wr_req_t     wr,
    output cltk_pkg::result_t     res0,
    output cltk_pkg::result_t     res1
);
    import cltk_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    typedef enum logic [1:0] {
        OTH_NONE,
        OTH_SINGLE,
        OTH_FAIL,
        OTH_OPEN
    } other_t;

    // byte count between two offsets, floored at zero and capped at 16 bits
    function automatic logic [15:0] span_len(input logic [POSITION_BITS-1:0] e,
                                             input logic [POSITION_BITS-1:0] s);
        logic [POSITION_BITS+15:0] d;
        logic [15:0]               r;
        d = {16'b0, e - s};
        if (e < s)
            r = '0;
        else if (|d[POSITION_BITS+15:16])
            r = '1;
        else
            r = d[15:0];
        return r;
    endfunction

    function automatic logic [15:0] low16(input logic [POSITION_BITS-1:0] p);
        logic [POSITION_BITS+15:0] z;
        z = {16'b0, p};
        return z[15:0];
    endfunction

    function automatic logic is_open(input mode_t m);
        return (m == MODE_NAME) || (m == MODE_NUMBER) || (m == MODE_OPERATOR);
    endfunction

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     slash_reg, slash_next;
    logic                     star_reg, star_next;

    logic                     fire;
    logic                     eot;
    cls_t                     cls;
    mode_t                    eff_mode;
    logic                     active;
    logic                     comment_open;
    logic                     close_en;
    logic                     close_prev;
    other_t                   oth;
    err_t                     fail_code;
    result_t                  c_res;
    result_t                  o_res;

    assign fire    = in_valid && room;
    assign in_take = fire;
    assign eot     = in_item.end_of_text;
    assign cls     = in_item.cls;

    // a held slash that opens no comment turns an idle lexer into an operator run
    assign eff_mode = (slash_reg && mode_reg == MODE_IDLE) ? MODE_OPERATOR : mode_reg;
    assign active   = (mode_reg == MODE_IDLE) || is_open(mode_reg);
    assign comment_open = slash_reg && (cls == CL_SLASH || cls == CL_STAR);

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        if (fire)
        begin
            if (eot)
            begin
                mode_next  = MODE_IDLE;
                start_next = '0;
                pos_next   = '0;
                slash_next = 1'b0;
                star_next  = 1'b0;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + POS_ONE;
                unique case (mode_reg)
                    MODE_HALT:
                    begin
                    end
                    MODE_LINE_COMMENT:
                    begin
                        if (cls == CL_NEWLINE)
                            mode_next = MODE_IDLE;
                    end
                    MODE_BLOCK_COMMENT:
                    begin
                        if (cls == CL_SLASH && star_reg)
                        begin
                            mode_next = MODE_IDLE;
                            star_next = 1'b0;
                        end
                        else
                            star_next = (cls == CL_STAR);
                    end
                    MODE_IDLE, MODE_NAME, MODE_NUMBER, MODE_OPERATOR:
                    begin
                        slash_next = 1'b0;
                        if (comment_open)
                        begin
                            mode_next  = (cls == CL_SLASH) ? MODE_LINE_COMMENT
                                                           : MODE_BLOCK_COMMENT;
                            start_next = pos_reg - POS_ONE;
                            star_next  = (cls == CL_STAR);
                        end
                        else
                        begin
                            unique case (cls) inside
                                CL_BLANK, CL_NEWLINE, CL_COMMA, CL_SEMI, CL_BRACKET:
                                    mode_next = MODE_IDLE;
                                CL_ALPHA, CL_SUFFIX:
                                begin
                                    if (eff_mode == MODE_NUMBER && cls == CL_ALPHA)
                                        mode_next = MODE_HALT;
                                    else if (eff_mode != MODE_NAME)
                                    begin
                                        mode_next  = MODE_NAME;
                                        start_next = pos_reg;
                                    end
                                end
                                CL_DIGIT:
                                begin
                                    if (eff_mode != MODE_NAME && eff_mode != MODE_NUMBER)
                                    begin
                                        mode_next  = MODE_NUMBER;
                                        start_next = pos_reg;
                                    end
                                end
                                CL_DOT:
                                begin
                                    if (eff_mode != MODE_NAME && eff_mode != MODE_NUMBER)
                                        mode_next = MODE_HALT;
                                end
                                CL_SLASH, CL_STAR, CL_OPER:
                                begin
                                    if (eff_mode == MODE_OPERATOR)
                                    begin
                                        mode_next  = MODE_OPERATOR;
                                        slash_next = (cls == CL_SLASH);
                                    end
                                    else
                                    begin
                                        // a lone slash waits for the next byte
                                        mode_next  = (cls == CL_SLASH) ? MODE_IDLE
                                                                       : MODE_OPERATOR;
                                        start_next = pos_reg;
                                        slash_next = (cls == CL_SLASH);
                                    end
                                end
                                default:
                                    mode_next = MODE_HALT;
                            endcase
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_HALT;
                    end
                endcase
            end
        end
    end

    // results of this byte
    always_comb
    begin
        close_en   = 1'b0;
        close_prev = 1'b0;
        oth        = OTH_NONE;
        fail_code  = ERR_NONE;
        if (eot)
        begin
            if (mode_reg == MODE_BLOCK_COMMENT)
                oth = OTH_OPEN;
            else if (mode_reg != MODE_HALT)
                close_en = is_open(eff_mode);
        end
        else if (active)
        begin
            if (comment_open)
            begin
                close_en   = (mode_reg == MODE_OPERATOR);
                close_prev = 1'b1;
            end
            else
            begin
                unique case (cls) inside
                    CL_BLANK, CL_NEWLINE:
                        close_en = is_open(eff_mode);
                    CL_COMMA, CL_SEMI, CL_BRACKET:
                    begin
                        close_en = is_open(eff_mode);
                        oth      = OTH_SINGLE;
                    end
                    CL_ALPHA, CL_SUFFIX:
                    begin
                        if (eff_mode == MODE_NUMBER && cls == CL_ALPHA)
                        begin
                            oth       = OTH_FAIL;
                            fail_code = ERR_LETTER_AFTER_NUMBER;
                        end
                        else if (eff_mode != MODE_NAME)
                            close_en = is_open(eff_mode);
                    end
                    CL_DIGIT:
                    begin
                        if (eff_mode != MODE_NAME && eff_mode != MODE_NUMBER)
                            close_en = is_open(eff_mode);
                    end
                    CL_DOT:
                    begin
                        if (eff_mode != MODE_NAME && eff_mode != MODE_NUMBER)
                        begin
                            oth       = OTH_FAIL;
                            fail_code = ERR_MISPLACED_DOT;
                        end
                    end
                    CL_SLASH, CL_STAR, CL_OPER:
                        close_en = (eff_mode == MODE_NAME) || (eff_mode == MODE_NUMBER);
                    default:
                    begin
                        oth       = OTH_FAIL;
                        fail_code = ERR_UNKNOWN_BYTE;
                    end
                endcase
            end
        end

        // token being closed
        unique case (eff_mode)
            MODE_NAME:   c_res.token_kind = KIND_NAME;
            MODE_NUMBER: c_res.token_kind = KIND_NUMBER;
            default:     c_res.token_kind = KIND_OPERATOR;
        endcase
        c_res.token_start  = low16(start_reg);
        c_res.token_length = span_len(close_prev ? pos_reg - POS_ONE : pos_reg, start_reg);
        c_res.single_char  = '0;
        c_res.error_code   = ERR_NONE;
        c_res.last_of_run  = (oth == OTH_NONE);

        // separator, error or unclosed comment
        o_res.token_kind   = KIND_ERROR;
        o_res.token_start  = low16(pos_reg);
        o_res.token_length = 16'd1;
        o_res.single_char  = '0;
        o_res.error_code   = fail_code;
        o_res.last_of_run  = 1'b1;
        unique case (oth)
            OTH_SINGLE:
            begin
                unique case (cls)
                    CL_COMMA: o_res.token_kind = KIND_COMMA;
                    CL_SEMI:  o_res.token_kind = KIND_SEMICOLON;
                    default:  o_res.token_kind = KIND_BRACKET;
                endcase
                o_res.single_char = in_item.char_code;
            end
            OTH_OPEN:
            begin
                o_res.token_start  = low16(start_reg);
                o_res.token_length = span_len(pos_reg, start_reg);
                o_res.error_code   = ERR_OPEN_COMMENT;
            end
            default:
            begin
            end
        endcase

        res0   = close_en ? c_res : o_res;
        res1   = o_res;
        wr.en0 = fire && (close_en || oth != OTH_NONE);
        wr.en1 = fire && close_en && oth != OTH_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cltk_result_fifo.sv
`default_nettype none

module cltk_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  cltk_pkg::wr_req_t wr,
    input  cltk_pkg::result_t wdata0,
    input  cltk_pkg::result_t wdata1,
    output logic              room,
    output logic              empty,
    input  logic              pop,
    output cltk_pkg::result_t rdata
);
    import cltk_pkg::*;

    localparam int PTR_BITS = $clog2(RESULT_DEPTH);
    localparam int CNT_BITS = $clog2(RESULT_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST  = PTR_BITS'(RESULT_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_ROOM2 = CNT_BITS'(RESULT_DEPTH - 2);

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    result_t             entry_reg [RESULT_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [PTR_BITS-1:0] wr_ptr_1;
    logic                do_pop;

    // the lexer may write two results at once, so it needs two free slots
    assign room     = (count_reg <= CNT_ROOM2);
    assign empty    = (count_reg == '0);
    assign do_pop   = pop && !empty;
    assign rdata    = entry_reg[rd_ptr_reg];
    assign wr_ptr_1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (wr.en1)
            wr_ptr_next = ptr_inc(wr_ptr_1);
        else if (wr.en0)
            wr_ptr_next = wr_ptr_1;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = CNT_BITS'(count_reg + CNT_BITS'(wr.en0) + CNT_BITS'(wr.en1)
                                - CNT_BITS'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en0)
        begin
            entry_reg[wr_ptr_reg] <= wdata0;
        end
        if (wr.en1)
        begin
            entry_reg[wr_ptr_1] <= wdata1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/c_like_source_tokenizer_unit.sv
// path: a pushed byte is registered in the front queue, then the lexer writes its results into the result queue
// throughput: one byte per cycle while the result queue has room; a byte closes at most two tokens' worth of results
// the lexer stalls only while the four-entry result queue has fewer than two free slots
// results are popped one per cycle, so a run of two-result bytes is paced by pop
// reset clears both queues and returns the lexer to idle at offset zero
// an end of text byte flushes the open token and returns the lexer to that same state
`default_nettype none

module c_like_source_tokenizer_unit #(
    parameter int POSITION_BITS = cltk_pkg::POSITION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cltk_pkg::in_item_t item,
    output logic               empty,
    input  logic               pop,
    output cltk_pkg::result_t  result
);
    import cltk_pkg::*;

    logic        fr_valid;
    logic        fr_take;
    class_item_t fr_item;
    logic        room;
    wr_req_t     wr;
    result_t     res0;
    result_t     res1;

    cltk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .out_valid (fr_valid),
        .out_take  (fr_take),
        .out_item  (fr_item)
    );

    cltk_lexer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fr_valid),
        .in_take  (fr_take),
        .in_item  (fr_item),
        .room     (room),
        .wr       (wr),
        .res0     (res0),
        .res1     (res1)
    );

    cltk_result_fifo u_result_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .wdata0 (res0),
        .wdata1 (res1),
        .room   (room),
        .empty  (empty),
        .pop    (pop),
        .rdata  (result)
    );

endmodule

`default_nettype wire

FILE: sv/cltk_checker.sv
`default_nettype none

module cltk_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input cltk_pkg::result_t result
);
    import cltk_pkg::*;

    // both queues come out of reset drained
    a_reset_drained: assert property (@(posedge clk)
        !rst_n |=> empty && !full)
        else $error("queues not drained in reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed");

    // results of one byte are written together, so the rest of a run is already queued
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !result.last_of_run |=> !empty)
        else $error("result run broken");

    a_error_length: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.token_kind == KIND_ERROR && result.error_code != ERR_OPEN_COMMENT
        |-> result.token_length == 16'd1)
        else $error("error result with length other than one");

    a_char_only_single: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (result.token_kind == KIND_NAME || result.token_kind == KIND_NUMBER ||
                   result.token_kind == KIND_OPERATOR || result.token_kind == KIND_ERROR)
        |-> result.single_char == 8'd0)
        else $error("character on a multi-byte or error result");

endmodule

bind c_like_source_tokenizer_unit cltk_checker u_cltk_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire
